### hdl/deque_with_range_fill_macros.svh
// assertion macros for the range-fill deque
`ifndef DEQUE_WITH_RANGE_FILL_MACROS_SVH
`define DEQUE_WITH_RANGE_FILL_MACROS_SVH

// same-cycle implication, checked on clk outside of reset
`define DQRF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deque check failed");

// next-cycle implication, checked on clk outside of reset
`define DQRF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deque check failed");

`endif

### hdl/dqrf_pkg.sv
// types and codes shared by the range-fill deque files
`timescale 1ns / 1ps
package dqrf_pkg;

  // field widths of the request and result words
  localparam int OP_W    = 3;
  localparam int VAL_W   = 32;
  localparam int RCNT_W  = 7;
  localparam int STAT_W  = 2;

  // request operation codes
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_DUMP       = 3'd4
  } op_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_ELEMENT   = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_EMIT,
    S_DUMP_RD,
    S_DUMP_OUT
  } fsm_t;

endpackage

### hdl/dqrf_if.sv
// valid/ready channel interfaces for request and result words
`timescale 1ns / 1ps

interface dqrf_in_if import dqrf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic signed [VAL_W-1:0]  range_start;
  logic signed [VAL_W-1:0]  range_step;
  logic signed [VAL_W-1:0]  range_end;
  logic [RCNT_W-1:0]        remove_count;

  modport source (output valid, operation, range_start, range_step, range_end,
                  remove_count, input ready);
  modport sink   (input valid, operation, range_start, range_step, range_end,
                  remove_count, output ready);
endinterface

interface dqrf_out_if import dqrf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [VAL_W-1:0]  item_value;
  logic [STAT_W-1:0]        status;
  logic                     last_of_run;

  modport source (output valid, item_value, status, last_of_run, input ready);
  modport sink   (input valid, item_value, status, last_of_run, output ready);
endinterface

### hdl/deque_with_range_fill.sv
// top level of the range-fill deque: ring store, sequencer and result register
//
// Bounded double-ended queue of signed 32-bit values in a ring store.
// in_ch carries request words (push range front/back, pop n front/back,
// dump); out_ch carries result words (dumped values, or an underflow or
// overflow status), the final word of a request flagged by last_of_run.
// Requests are taken one at a time, in_ch.ready is high while the
// sequencer is idle; a request is accepted when valid and ready are high.
// Steps of each request, set by the ring store's registered read port
// and the one-word result register:
//   push range: accept, then write each value in turn until the range
//               end is passed (full store: emit an overflow status)
//   pop n:      accept and remove, then emit an underflow status if n exceeds the count
//   dump:       accept, then for each stored word a read and a load
// A stalled receiver holds the result register; the sequencer waits and
// takes no new request until its own results are loaded. A request that
// leaves a result waiting can be followed by the next request at once.
// Reset (rst_n low, synchronous) empties the deque: front index and count
// go to zero and the result valid flag is cleared. Store contents are not
// reset; only written entries are ever read.
`timescale 1ns / 1ps
`include "deque_with_range_fill_macros.svh"

module deque_with_range_fill
  import dqrf_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  dqrf_in_if.sink    in_ch,
  dqrf_out_if.source out_ch
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int CUR_W = VAL_W + 2;

  // ring store, one write and one registered read port
  logic [VAL_W-1:0] mem [DEPTH];
  logic             mem_we;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;
  logic [VAL_W-1:0] rd_data_r;

  // control state
  fsm_t             state_r, state_nxt;
  logic [IDX_W-1:0] front_r, front_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  status_t          pend_r, pend_nxt;

  // request operands held while a range is generated
  logic signed [CUR_W-1:0] cur_r, cur_nxt;
  logic signed [CUR_W-1:0] step_r, step_nxt;
  logic signed [CUR_W-1:0] end_r, end_nxt;
  logic                    at_front_r, at_front_nxt;

  // result register
  logic             out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0] out_value_r, out_value_nxt;
  status_t          out_status_r, out_status_nxt;
  logic             out_last_r, out_last_nxt;

  logic             in_fire;
  logic             out_free;
  logic [RCNT_W-1:0] pop_n;
  logic [CNT_W-1:0] pop_k;
  logic             pop_under;
  logic             step_pos;

  // ring position base + offset, offset at most DEPTH
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);

  // pop amount clipped to what is stored
  assign pop_n     = in_ch.remove_count;
  assign pop_under = pop_n > RCNT_W'(count_r);
  assign pop_k     = pop_under ? count_r : CNT_W'(pop_n);
  assign step_pos  = !in_ch.range_step[VAL_W-1] && (in_ch.range_step != '0);

  assign rd_addr = ring_add(front_r, idx_r);

  // store write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= cur_r[VAL_W-1:0];
    end
    rd_data_r <= mem[rd_addr];
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // operand and payload registers
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    pend_r       <= pend_nxt;
    cur_r        <= cur_nxt;
    step_r       <= step_nxt;
    end_r        <= end_nxt;
    at_front_r   <= at_front_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  // sequencer: next state, store access and result loading
  always_comb begin
    state_nxt      = state_r;
    front_nxt      = front_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    pend_nxt       = pend_r;
    cur_nxt        = cur_r;
    step_nxt       = step_r;
    end_nxt        = end_r;
    at_front_nxt   = at_front_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    wr_addr        = ring_add(front_r, count_r);

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (op_t'(in_ch.operation))
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              cur_nxt      = CUR_W'(in_ch.range_start);
              step_nxt     = CUR_W'(in_ch.range_step);
              end_nxt      = CUR_W'(in_ch.range_end);
              at_front_nxt = (op_t'(in_ch.operation) == OP_PUSH_FRONT);
              if (step_pos) begin
                state_nxt = S_PUSH;
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              count_nxt = count_r - pop_k;
              if (op_t'(in_ch.operation) == OP_POP_FRONT) begin
                front_nxt = ring_add(front_r, pop_k);
              end
              if (pop_under) begin
                pend_nxt  = ST_UNDERFLOW;
                state_nxt = S_EMIT;
              end
            end
            OP_DUMP: begin
              idx_nxt = '0;
              if (count_r != '0) begin
                state_nxt = S_DUMP_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // one range value per cycle
      S_PUSH: begin
        if (cur_r > end_r) begin
          state_nxt = S_IDLE;
        end else if (count_r == CNT_W'(DEPTH)) begin
          pend_nxt  = ST_OVERFLOW;
          state_nxt = S_EMIT;
        end else begin
          mem_we    = 1'b1;
          count_nxt = count_r + 1'b1;
          cur_nxt   = cur_r + step_r;
          if (at_front_r) begin
            front_nxt = (front_r == '0) ? IDX_W'(DEPTH - 1) : front_r - 1'b1;
            wr_addr   = front_nxt;
          end
        end
      end

      // status word for a stopped push or pop
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = '0;
          out_status_nxt = pend_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      // read address settles, data registered at the edge
      S_DUMP_RD: begin
        state_nxt = S_DUMP_OUT;
      end

      S_DUMP_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = rd_data_r;
          out_status_nxt = ST_ELEMENT;
          out_last_nxt   = (idx_r + 1'b1 == count_r);
          idx_nxt        = idx_r + 1'b1;
          state_nxt      = (idx_r + 1'b1 == count_r) ? S_IDLE : S_DUMP_RD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.item_value  = out_value_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.last_of_run = out_last_r;

  // checks on the sequencer and ring bookkeeping
  `DQRF_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(DEPTH))
  `DQRF_ASSERT_NOW(a_front_bound, 1'b1, SUM_W'(front_r) < SUM_W'(DEPTH))
  `DQRF_ASSERT_NOW(a_write_room, mem_we, state_r == S_PUSH && count_r < CNT_W'(DEPTH))
  `DQRF_ASSERT_NEXT(a_dump_keeps_count, state_r == S_DUMP_OUT, count_r == $past(count_r))
  `DQRF_ASSERT_NOW(a_emit_status, state_r == S_EMIT,
                   pend_r == ST_UNDERFLOW || pend_r == ST_OVERFLOW)

endmodule

### tb/tb.sv
// testbench for the range-fill deque: directed table, then random requests
`timescale 1ns / 1ps

module tb
  import dqrf_pkg::*;
();

  localparam int DEPTH        = 64;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 64;
  localparam int PHASE_WORDS  = 26;

  localparam logic [VAL_W-1:0] MIN_VAL = 32'h8000_0000;
  localparam logic [VAL_W-1:0] MAX_VAL = 32'h7fff_ffff;

  // operation codes the block leaves unused
  localparam logic [OP_W-1:0] OP_RSVD_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_HI = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [VAL_W-1:0]  first;
    logic [VAL_W-1:0]  stride;
    logic [VAL_W-1:0]  limit;
    logic [RCNT_W-1:0] cnt;
  } req_t;

  typedef struct packed {
    logic [VAL_W-1:0]  value;
    logic [STAT_W-1:0] status;
    logic              last;
  } word_t;

  // how a directed row is checked: by the shadow deque, by a typed-in answer, or not at all
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_UNDER, CHK_OVER} chk_t;

  typedef struct packed {
    chk_t chk;
    req_t req;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;

  dqrf_in_if  in_ch ();
  dqrf_out_if out_ch ();

  deque_with_range_fill #(.DEPTH(DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the deque
  logic [VAL_W-1:0] shadow_store [0:DEPTH-1];
  logic [5:0]       shadow_front;
  logic [6:0]       shadow_count;

  word_t step_words [$];
  word_t awaited_words [$];
  row_t  directed_rows [$];

  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;
  int quiet_cycles;

  word_t got_word;
  word_t want_word;

  function automatic word_t mk_word(logic [VAL_W-1:0] v, logic [STAT_W-1:0] s, logic l);
    word_t w;
    w.value  = v;
    w.status = s;
    w.last   = l;
    return w;
  endfunction

  // apply one request to the shadow deque, leaving its result words in step_words
  function automatic void deque_apply(input req_t r);
    longint     cur;
    longint     stp;
    longint     lim;
    logic [5:0] idx;
    int         i;
    step_words.delete();
    case (r.op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        cur = longint'($signed(r.first));
        stp = longint'($signed(r.stride));
        lim = longint'($signed(r.limit));
        if (stp > 0) begin
          while (cur <= lim) begin
            if (shadow_count >= DEPTH) begin
              step_words = {step_words, mk_word('0, ST_OVERFLOW, 1'b1)};
              break;
            end
            if (r.op == OP_PUSH_FRONT) begin
              shadow_front = shadow_front - 6'd1;
              shadow_store[shadow_front] = cur[VAL_W-1:0];
            end else begin
              idx = shadow_front + shadow_count[5:0];
              shadow_store[idx] = cur[VAL_W-1:0];
            end
            shadow_count = shadow_count + 7'd1;
            cur = cur + stp;
          end
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        for (i = 0; i < int'(r.cnt); i++) begin
          if (shadow_count == 0) begin
            step_words = {step_words, mk_word('0, ST_UNDERFLOW, 1'b1)};
            break;
          end
          if (r.op == OP_POP_FRONT) shadow_front = shadow_front + 6'd1;
          shadow_count = shadow_count - 7'd1;
        end
      end
      OP_DUMP: begin
        for (i = 0; i < int'(shadow_count); i++) begin
          idx = shadow_front + i[5:0];
          step_words = {step_words, mk_word(shadow_store[idx], ST_ELEMENT,
                                            (i + 1 == int'(shadow_count)))};
        end
      end
      default: ;
    endcase
  endfunction

  task automatic add_row(input chk_t c, input logic [OP_W-1:0] op, input logic [VAL_W-1:0] a,
                         input logic [VAL_W-1:0] b, input logic [VAL_W-1:0] e,
                         input logic [RCNT_W-1:0] n);
    row_t rw;
    rw.chk        = c;
    rw.req.op     = op;
    rw.req.first  = a;
    rw.req.stride = b;
    rw.req.limit  = e;
    rw.req.cnt    = n;
    directed_rows = {directed_rows, rw};
  endtask

  // mostly well-formed requests with random content, a few pure noise words
  function automatic req_t random_request();
    req_t   r;
    int     pick;
    int     k;
    longint lim;
    r.op     = OP_DUMP;
    r.first  = $urandom;
    r.stride = $urandom;
    r.limit  = $urandom;
    r.cnt    = RCNT_W'($urandom);
    pick     = $urandom_range(0, 99);
    if (pick < 6) begin
      r.op = OP_W'($urandom);
    end else if (pick < 58) begin
      r.op = (pick < 36) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      if ($urandom_range(0, 7) == 0) r.first = MAX_VAL - $urandom_range(0, 40);
      else if ($urandom_range(0, 7) == 0) r.first = MIN_VAL + $urandom_range(0, 40);
      if ($urandom_range(0, 3) == 0) r.stride = $urandom_range(32'h7fff_ffff, 1);
      else r.stride = $urandom_range(9, 1);
      k = ($urandom_range(0, 9) == 0) ? $urandom_range(70, 30) : $urandom_range(12, 0);
      lim = longint'($signed(r.first)) + longint'($signed(r.stride)) * k;
      r.limit = (lim > longint'($signed(MAX_VAL))) ? MAX_VAL : lim[VAL_W-1:0];
      // broken range: start above end or non-positive step
      if ($urandom_range(0, 9) == 0) r.limit = r.first - $urandom_range(40, 1);
      else if ($urandom_range(0, 9) == 0) r.stride = -$urandom_range(5, 0);
    end else if (pick < 88) begin
      r.op  = (pick < 73) ? OP_POP_FRONT : OP_POP_BACK;
      if ($urandom_range(0, 9) != 0) r.cnt = RCNT_W'($urandom_range(12, 0));
    end
    return r;
  endfunction

  // drive one request word and record what it should produce once taken
  task automatic send_word(input req_t w, input chk_t chk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid     <= 1'b0;
      in_ch.operation <= OP_W'($urandom);
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.operation    <= w.op;
    in_ch.range_start  <= w.first;
    in_ch.range_step   <= w.stride;
    in_ch.range_end    <= w.limit;
    in_ch.remove_count <= w.cnt;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    deque_apply(w);
    case (chk)
      CHK_MODEL: awaited_words = {awaited_words, step_words};
      CHK_UNDER: awaited_words = {awaited_words, mk_word('0, ST_UNDERFLOW, 1'b1)};
      CHK_OVER:  awaited_words = {awaited_words, mk_word('0, ST_OVERFLOW, 1'b1)};
      default: ;
    endcase
  endtask

  task automatic log_mismatch(input string what, input word_t want, input word_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch (%s): expected value %0d status %0d last %0d", what,
               $signed(want.value), want.status, want.last);
      $display("                 got value %0d status %0d last %0d",
               $signed(got.value), got.status, got.last);
    end
  endtask

  // result side: random stalls, compare each word with the oldest one awaited
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_word = mk_word(out_ch.item_value, out_ch.status, out_ch.last_of_run);
      if (awaited_words.size() == 0) begin
        log_mismatch("no word awaited", '0, got_word);
      end else begin
        want_word = awaited_words.pop_front();
        if (got_word.value !== want_word.value || got_word.status !== want_word.status ||
            got_word.last !== want_word.last)
          log_mismatch("field", want_word, got_word);
      end
    end
    out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // stimulus
  initial begin
    int ph;
    int n;
    in_ch.valid        <= 1'b0;
    in_ch.operation    <= '0;
    in_ch.range_start  <= '0;
    in_ch.range_step   <= '0;
    in_ch.range_end    <= '0;
    in_ch.remove_count <= '0;
    rst_n              <= 1'b0;
    mismatches          = 0;
    shadow_front        = '0;
    shadow_count        = '0;
    for (n = 0; n < DEPTH; n++) shadow_store[n] = '0;
    send_idle_pct = 18;
    recv_idle_pct = 81;

    // pops and dump on the empty deque after reset
    add_row(CHK_UNDER, OP_POP_FRONT, 0, 0, 0, 1);
    add_row(CHK_NONE,  OP_POP_BACK,  0, 0, 0, 0);
    add_row(CHK_NONE,  OP_DUMP,      0, 0, 0, 0);
    // ranges that add nothing: zero step, most negative step, start above end
    add_row(CHK_NONE,  OP_PUSH_BACK,  0, 0, 10, 0);
    add_row(CHK_NONE,  OP_PUSH_BACK,  5, MIN_VAL, 10, 0);
    add_row(CHK_NONE,  OP_PUSH_FRONT, 10, 1, 5, 0);
    // plain pushes at both ends
    add_row(CHK_NONE,  OP_PUSH_BACK,  1, 1, 3, 0);
    add_row(CHK_NONE,  OP_PUSH_FRONT, -2, 2, 0, 0);
    add_row(CHK_MODEL, OP_DUMP,       0, 0, 0, 0);
    // unused operation codes leave the deque as it was
    add_row(CHK_NONE,  OP_RSVD_LO, MAX_VAL, MAX_VAL, MAX_VAL, 7'h7f);
    add_row(CHK_NONE,  OP_RSVD_HI, MIN_VAL, 1, MAX_VAL, 7'h7f);
    add_row(CHK_MODEL, OP_DUMP,    0, 0, 0, 0);
    add_row(CHK_NONE,  OP_POP_BACK,  0, 0, 0, 2);
    add_row(CHK_NONE,  OP_POP_FRONT, 0, 0, 0, 1);
    add_row(CHK_MODEL, OP_DUMP,      0, 0, 0, 0);
    // ranges that stop short of wrapping near the 32-bit limits
    add_row(CHK_NONE,  OP_PUSH_BACK,  32'h7fff_fff8, 5, MAX_VAL, 0);
    add_row(CHK_NONE,  OP_PUSH_FRONT, MIN_VAL, MAX_VAL, MAX_VAL, 0);
    add_row(CHK_MODEL, OP_DUMP,       0, 0, 0, 0);
    // pop past empty, then fill past full
    add_row(CHK_UNDER, OP_POP_FRONT, 0, 0, 0, 7'h7f);
    add_row(CHK_OVER,  OP_PUSH_BACK, MIN_VAL, 1, MAX_VAL, 0);
    add_row(CHK_MODEL, OP_DUMP,       0, 0, 0, 0);
    add_row(CHK_OVER,  OP_PUSH_FRONT, 0, 1, 0, 0);
    add_row(CHK_NONE,  OP_POP_BACK,   0, 0, 0, RCNT_W'(DEPTH));
    add_row(CHK_NONE,  OP_DUMP,       0, 0, 0, 0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (n = 0; n < directed_rows.size(); n++)
      send_word(directed_rows[n].req, directed_rows[n].chk);

    // random requests under three idling mixes
    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 18; recv_idle_pct = 81; end
        1: begin send_idle_pct = 81; recv_idle_pct = 18; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      repeat (PHASE_WORDS) send_word(random_request(), CHK_MODEL);
    end
    in_ch.valid <= 1'b0;

    // drain and end
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    mismatches += awaited_words.size();
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
